// File: rtl/fixed_point_log2_interp_macros.svh
// Assertion helpers used by the checker module
`ifndef FIXED_POINT_LOG2_INTERP_MACROS_SVH
`define FIXED_POINT_LOG2_INTERP_MACROS_SVH

// same-cycle implication, masked during reset
`define FPL2_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define FPL2_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fpl2_pkg.sv
`timescale 1ns / 1ps
package fpl2_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned EXP_W    = 5;
  localparam int unsigned SEG_W    = 6;
  localparam int unsigned FRAC_W   = 25;   // bits below the segment index after normalising
  localparam int unsigned QFRAC_W  = 15;
  localparam int unsigned LOG_W    = 20;
  localparam int unsigned MANT_W   = 16;
  localparam int unsigned DIFF_W   = 10;   // largest step between entries is 733
  localparam int unsigned TAB_N    = 65;
  localparam int unsigned TAB_IDX_W = 7;

  typedef struct packed {
    logic [EXP_W-1:0]  expo;
    logic [SEG_W-1:0]  idx;
    logic [FRAC_W-1:0] frac;
    logic              zero;
  } norm_t;

  // round(32768 * log2(1 + k/64))
  localparam logic [MANT_W-1:0] MANT_TAB [0:TAB_N-1] = '{
    16'd0,     16'd733,   16'd1455,  16'd2166,  16'd2866,  16'd3556,  16'd4236,  16'd4907,
    16'd5568,  16'd6220,  16'd6863,  16'd7498,  16'd8124,  16'd8742,  16'd9352,  16'd9954,
    16'd10549, 16'd11136, 16'd11716, 16'd12289, 16'd12855, 16'd13415, 16'd13968, 16'd14514,
    16'd15055, 16'd15589, 16'd16117, 16'd16639, 16'd17156, 16'd17667, 16'd18173, 16'd18673,
    16'd19168, 16'd19658, 16'd20143, 16'd20623, 16'd21098, 16'd21568, 16'd22034, 16'd22495,
    16'd22952, 16'd23404, 16'd23852, 16'd24296, 16'd24736, 16'd25172, 16'd25604, 16'd26031,
    16'd26455, 16'd26876, 16'd27292, 16'd27705, 16'd28114, 16'd28520, 16'd28922, 16'd29321,
    16'd29717, 16'd30109, 16'd30498, 16'd30884, 16'd31267, 16'd31647, 16'd32024, 16'd32397,
    16'd32768
  };

endpackage

// File: rtl/fpl2_norm.sv
`timescale 1ns / 1ps
module fpl2_norm (
  input  logic [31:0]     value,
  output fpl2_pkg::norm_t norm
);
  import fpl2_pkg::*;

  logic [EXP_W-1:0]   expo;
  logic [VALUE_W-1:0] shifted;

  // leading-one position, highest set bit wins
  always_comb begin
    expo = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (value[i]) begin
        expo = EXP_W'(i);
      end
    end
  end

  // leading one to the top bit: segment index and fraction fall out at fixed places,
  // and short values get zero fraction for free
  assign shifted = value << (EXP_W'(VALUE_W - 1) - expo);

  always_comb begin
    norm.expo = expo;
    norm.idx  = shifted[VALUE_W-2 -: SEG_W];
    norm.frac = shifted[FRAC_W-1:0];
    norm.zero = (value == '0);
  end

endmodule

// File: rtl/fixed_point_log2_interp.sv
`timescale 1ns / 1ps
// A request passes through the input register, the normalise register and the result
// register before its result is valid on the port.
// Throughput: one request per cycle unless the output stalls; each stage refills as
// soon as it empties.
// Reset (rst_n low, synchronous) clears all stage valid flags; payload is not reset.
module fixed_point_log2_interp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] linear_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [19:0] log_q15, [23:20] zero padding
  output logic        out_tuser   // [0] zero_input
);
  import fpl2_pkg::*;

  logic [VALUE_W-1:0] in_data_r;
  logic               in_vld_r;
  norm_t              mid_r;
  logic               mid_vld_r;
  logic [LOG_W-1:0]   out_log_r;
  logic               out_zero_r;
  logic               out_vld_r;

  logic               rdy_out, rdy_mid, rdy_in;
  norm_t              norm;

  logic [MANT_W-1:0]        lo, hi;
  logic [DIFF_W-1:0]        diff;
  logic [FRAC_W+DIFF_W-1:0] prod;
  logic [DIFF_W-1:0]        interp;
  logic [LOG_W-1:0]         sum;
  logic [LOG_W-1:0]         out_log_nxt;

  assign rdy_out   = !out_vld_r || out_tready;
  assign rdy_mid   = !mid_vld_r || rdy_out;
  assign rdy_in    = !in_vld_r  || rdy_mid;
  assign in_tready = rdy_in;

  fpl2_norm u_norm (
    .value (in_data_r),
    .norm  (norm)
  );

  always_comb begin
    lo     = MANT_TAB[{1'b0, mid_r.idx}];
    hi     = MANT_TAB[{1'b0, mid_r.idx} + TAB_IDX_W'(1)];
    diff   = DIFF_W'(hi - lo);
    prod   = (FRAC_W+DIFF_W)'(mid_r.frac) * (FRAC_W+DIFF_W)'(diff);
    interp = prod[FRAC_W+DIFF_W-1:FRAC_W];
    sum    = {mid_r.expo, {QFRAC_W{1'b0}}} + LOG_W'(lo) + LOG_W'(interp);
    out_log_nxt = mid_r.zero ? '0 : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      mid_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy_in) begin
        in_vld_r <= in_tvalid;
      end
      if (rdy_mid) begin
        mid_vld_r <= in_vld_r;
      end
      if (rdy_out) begin
        out_vld_r <= mid_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_in && in_tvalid) begin
      in_data_r <= in_tdata;
    end
    if (rdy_mid && in_vld_r) begin
      mid_r <= norm;
    end
    if (rdy_out && mid_vld_r) begin
      out_log_r  <= out_log_nxt;
      out_zero_r <= mid_r.zero;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, out_log_r};
  assign out_tuser  = out_zero_r;

endmodule

// File: rtl/fpl2_checker.sv
`timescale 1ns / 1ps
`include "fixed_point_log2_interp_macros.svh"
module fpl2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  `FPL2_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `FPL2_ASSERT_NOW(a_zero_log, clk, rst_n, out_tvalid && out_tuser, out_tdata == 24'd0, "zero input gave nonzero log")
  `FPL2_ASSERT_NOW(a_pad_bits, clk, rst_n, out_tvalid, out_tdata[23:20] == 4'd0, "padding bits set")
  `FPL2_ASSERT_NOW(a_ready_empty, clk, rst_n, !out_tvalid, in_tready, "input stalled with empty output")
  `FPL2_ASSERT_NOW(a_reset_empty, clk, rst_n, $past(!rst_n), !out_tvalid, "result valid straight after reset")

endmodule

bind fixed_point_log2_interp fpl2_checker u_fpl2_checker (.*);

// File: dv/tb_fixed_point_log2_interp.sv
`timescale 1ns / 1ps
module tb_fixed_point_log2_interp;
  import fpl2_pkg::VALUE_W;
  import fpl2_pkg::LOG_W;

  localparam int unsigned SEG_BITS     = 6;
  localparam int unsigned QFRAC_BITS   = 15;
  localparam int unsigned SETTLE_CYC   = 8;     // pipeline is three stages deep
  localparam int unsigned HOLD_CYC     = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_COUNT = 600;

  // log2(1 + k/64) in Q15, 65 entries so that segment 63 has an upper end
  localparam logic [15:0] log2_mant [0:64] = '{
    16'd0,     16'd733,   16'd1455,  16'd2166,  16'd2866,  16'd3556,  16'd4236,  16'd4907,
    16'd5568,  16'd6220,  16'd6863,  16'd7498,  16'd8124,  16'd8742,  16'd9352,  16'd9954,
    16'd10549, 16'd11136, 16'd11716, 16'd12289, 16'd12855, 16'd13415, 16'd13968, 16'd14514,
    16'd15055, 16'd15589, 16'd16117, 16'd16639, 16'd17156, 16'd17667, 16'd18173, 16'd18673,
    16'd19168, 16'd19658, 16'd20143, 16'd20623, 16'd21098, 16'd21568, 16'd22034, 16'd22495,
    16'd22952, 16'd23404, 16'd23852, 16'd24296, 16'd24736, 16'd25172, 16'd25604, 16'd26031,
    16'd26455, 16'd26876, 16'd27292, 16'd27705, 16'd28114, 16'd28520, 16'd28922, 16'd29321,
    16'd29717, 16'd30109, 16'd30498, 16'd30884, 16'd31267, 16'd31647, 16'd32024, 16'd32397,
    16'd32768
  };

  typedef struct {
    logic [LOG_W-1:0] log_q15;
    logic             zero_input;
  } log_result_t;

  typedef enum int {RX_FLOW, RX_COIN, RX_SPARSE} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [23:0]        out_tdata;
  logic               out_tuser;

  log_result_t  expected_logs [$];
  int unsigned  mismatches = 0;
  int unsigned  burst_left = 0;
  bit           steady_stream = 1'b0;
  bit           hold_off_req = 1'b0;
  int unsigned  idle_cycles = 0;

  fixed_point_log2_interp dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic log_result_t predict_log2(input logic [VALUE_W-1:0] v);
    log_result_t r;
    int unsigned e;
    int unsigned sh;
    int unsigned idx;
    logic [63:0] frac;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] interp;
    logic [63:0] acc;
    r.log_q15 = '0;
    r.zero_input = 1'b0;
    if (v == '0) begin
      r.zero_input = 1'b1;
      return r;
    end
    e = 0;
    for (int p = 0; p < VALUE_W; p++)
      if (v[p]) e = p;
    if (e >= SEG_BITS) begin
      sh = e - SEG_BITS;
      idx = (v >> sh) & 32'h3F;
      frac = 64'(v) & ((64'd1 << sh) - 64'd1);
    end else begin
      // short values: normalise up, no interpolation
      sh = 0;
      idx = (v << (SEG_BITS - e)) & 32'h3F;
      frac = '0;
    end
    lo = 64'(log2_mant[idx]);
    hi = 64'(log2_mant[idx + 1]);
    interp = (frac * (hi - lo)) >> sh;
    acc = (64'(e) << QFRAC_BITS) + lo + interp;
    r.log_q15 = acc[LOG_W-1:0];
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] random_linear();
    int unsigned kind;
    int unsigned e;
    logic [VALUE_W-1:0] v;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      v = '0;
    end else if (kind <= 3) begin
      v = $urandom;
    end else begin
      // spread the leading one evenly over every position
      e = $urandom_range(0, VALUE_W - 1);
      v = (32'd1 << e) | (32'($urandom) & ((32'd1 << e) - 32'd1));
    end
    return v;
  endfunction

  task automatic send_request(input logic [VALUE_W-1:0] v);
    int unsigned gap;
    gap = 0;
    if (!steady_stream && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    expected_logs.push_back(predict_log2(v));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic drain_results();
    stop_sending();
    while (expected_logs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [VALUE_W-1:0] corner [$];
    corner = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h5, 32'h3F, 32'h40, 32'h41, 32'h7F,
               32'h80, 32'hFF, 32'h1FF, 32'h0001_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFC00_0000,
               32'hFDFF_FFFF, 32'hFFFF_FFC0, 32'hFFFF_FFFF, 32'h0};
    foreach (corner[i]) send_request(corner[i]);
    drain_results();
  endtask

  task automatic test_random_values();
    repeat (RANDOM_COUNT) send_request(random_linear());
    drain_results();
  endtask

  // output held off long enough for the pipeline to fill and back up the input
  task automatic test_output_backpressure();
    steady_stream = 1'b1;
    hold_off_req = 1'b1;
    repeat (40) send_request(random_linear());
    steady_stream = 1'b0;
    drain_results();
  endtask

  task automatic test_pause_between_requests();
    repeat (8) send_request(random_linear());
    drain_results();
    repeat (8) send_request(random_linear());
    drain_results();
  endtask

  // receiver readiness, with occasional long hold-off on request
  initial begin
    rx_mode_t mode;
    int unsigned mode_left;
    mode = RX_FLOW;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          RX_FLOW: out_tready <= 1'b1;
          RX_COIN: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    log_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_logs.size() == 0) begin
        $error("unexpected result: log_q15 %0d zero_input %0d", out_tdata[19:0], out_tuser);
        mismatches++;
      end else begin
        want = expected_logs.pop_front();
        if (out_tdata[19:0] !== want.log_q15) begin
          $error("log_q15: expected %0d, got %0d", want.log_q15, out_tdata[19:0]);
          mismatches++;
        end
        if (out_tuser !== want.zero_input) begin
          $error("zero_input: expected %0d, got %0d", want.zero_input, out_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_values();
    test_output_backpressure();
    test_pause_between_requests();
    if (mismatches == 0 && expected_logs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/fpl2_pkg.sv
rtl/fpl2_norm.sv
rtl/fixed_point_log2_interp.sv
rtl/fpl2_checker.sv
dv/tb_fixed_point_log2_interp.sv
